### src/mrcr_pkg.sv
package mrcr_pkg;

   // Matrix geometry.
   localparam int MAX_ROWS = 16;
   localparam int MAX_COLS = 16;
   localparam int MAX_LEN  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;

   // Field widths.
   localparam int FUNC_W    = 4;
   localparam int IDX_W     = 5;
   localparam int Q_W       = 32;
   localparam int CNT_W     = 5;
   localparam int CSR_IDX_W = 1;

   // Derived widths.
   localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int ACC_W     = Q_W + LEN_W;
   localparam int DIV_CNT_W = $clog2(ACC_W + 1);

   // Function codes.
   localparam logic [FUNC_W-1:0] FN_WRITE    = 4'd0;
   localparam logic [FUNC_W-1:0] FN_ROW_SUM  = 4'd1;
   localparam logic [FUNC_W-1:0] FN_COL_SUM  = 4'd2;
   localparam logic [FUNC_W-1:0] FN_ROW_MAX  = 4'd3;
   localparam logic [FUNC_W-1:0] FN_COL_MAX  = 4'd4;
   localparam logic [FUNC_W-1:0] FN_ROW_MIN  = 4'd5;
   localparam logic [FUNC_W-1:0] FN_COL_MIN  = 4'd6;
   localparam logic [FUNC_W-1:0] FN_ROW_MEAN = 4'd7;
   localparam logic [FUNC_W-1:0] FN_COL_MEAN = 4'd8;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'd1;
   localparam logic [CNT_W-1:0]     COUNT_RST     = 5'd16;

   // Cell store write port.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [Q_W-1:0]    data;
   } mem_wr_type;

   // Divider request and answer.
   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] dividend;
      logic [LEN_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] quotient;
   } div_rsp_type;

   // Row-major cell address.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
   endfunction

   // Clamp a wide accumulator into the Q16.16 range.
   function automatic logic [Q_W-1:0] sat_q32(input logic [ACC_W-1:0] v);
      logic [ACC_W-Q_W:0] hi;
      hi = v[ACC_W-1:Q_W-1];
      if ((&hi) || (~|hi)) begin
         return v[Q_W-1:0];
      end
      return v[ACC_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
   endfunction

endpackage

### src/mrcr_intf.sv
// Request channel: one beat per write or query.
interface mrcr_req_if import mrcr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [IDX_W-1:0]      row_index;
   logic [IDX_W-1:0]      col_index;
   logic signed [Q_W-1:0] operand_value;

   modport source(output valid, func, row_index, col_index, operand_value, input ready);
   modport sink(input valid, func, row_index, col_index, operand_value, output ready);
endinterface

// Response channel: one beat per request.
interface mrcr_rsp_if import mrcr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] result_value;
   logic                  status;

   modport source(output valid, result_value, status, input ready);
   modport sink(input valid, result_value, status, output ready);
endinterface

// Register write channel.
interface mrcr_csr_if import mrcr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CNT_W-1:0]     data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### src/matrix_row_column_reduce_top.sv
// Writes, index errors and unused codes pass from idle to the done state, then the answer register.
// Sum, max and min walk the row or column one cell per cycle through the single
// read port of the cell store, then pass the flush and finish states before done.
// Mean adds a bit-serial divider of ACC_W steps between the finish and done states.
// One request is worked at a time; a new beat is taken while the answer waits.
// Synchronous active-high reset sets both sizes to 16; cells hold no reset value.
module matrix_row_column_reduce_top import mrcr_pkg::*; (
   input logic      clock,
   input logic      reset,
   mrcr_req_if.sink   req_bus,
   mrcr_rsp_if.source rsp_bus,
   mrcr_csr_if.sink   csr_bus
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_FLUSH = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        row_count_ff, row_count_in;
   logic [CNT_W-1:0]        col_count_ff, col_count_in;
   logic                    by_row_ff, by_row_in;
   logic                    sum_mode_ff, sum_mode_in;
   logic                    max_mode_ff, max_mode_in;
   logic                    mean_ff, mean_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        cnt_ff, cnt_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic                    rd_first_ff, rd_first_in;
   logic [Q_W-1:0]          res_ff, res_in;
   logic                    sts_ff, sts_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]          rsp_value_ff, rsp_value_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    req_fire;
   logic [LEN_W-1:0]        eff_rows;
   logic [LEN_W-1:0]        eff_cols;
   logic                    idx_bad;
   logic [ROW_W-1:0]        req_row;
   logic [COL_W-1:0]        req_col;
   logic                    fn_known;
   logic                    fn_write;
   logic                    fn_sum;
   logic                    fn_max;
   logic                    fn_mean;

   mem_wr_type              mem_wr;
   logic [ADDR_W-1:0]       rd_addr;
   logic signed [Q_W-1:0]   rd_data;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic                    div_start;

   logic [ACC_W-1:0]        data_ext;
   logic [ACC_W-1:0]        op_a;
   logic [ACC_W-1:0]        op_b;
   logic [ACC_W-1:0]        alu_out;
   logic                    take;

   // Register port: always ready; the sizes are meant to change only between requests.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ROW_COUNT: row_count_in = csr_bus.data;
            CSR_COL_COUNT: col_count_in = csr_bus.data;
         endcase
      end
   end

   // Effective sizes clamp the registers to 1..MAX.
   always_comb begin
      if (row_count_ff == '0) begin
         eff_rows = LEN_W'(1);
      end else if (row_count_ff > MAX_ROWS) begin
         eff_rows = LEN_W'(MAX_ROWS);
      end else begin
         eff_rows = LEN_W'(row_count_ff);
      end
      if (col_count_ff == '0) begin
         eff_cols = LEN_W'(1);
      end else if (col_count_ff > MAX_COLS) begin
         eff_cols = LEN_W'(MAX_COLS);
      end else begin
         eff_cols = LEN_W'(col_count_ff);
      end
   end

   // Request decode.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign idx_bad       = (req_bus.row_index == '0) || (req_bus.row_index > eff_rows) ||
                          (req_bus.col_index == '0) || (req_bus.col_index > eff_cols);
   assign req_row       = ROW_W'(req_bus.row_index - 1'b1);
   assign req_col       = COL_W'(req_bus.col_index - 1'b1);

   always_comb begin
      fn_known = 1'b1;
      fn_write = 1'b0;
      fn_sum   = 1'b0;
      fn_max   = 1'b0;
      fn_mean  = 1'b0;
      unique case (req_bus.func)
         FN_WRITE:                 fn_write = 1'b1;
         FN_ROW_SUM, FN_COL_SUM:   fn_sum   = 1'b1;
         FN_ROW_MAX, FN_COL_MAX:   fn_max   = 1'b1;
         FN_ROW_MIN, FN_COL_MIN:   fn_max   = 1'b0;
         FN_ROW_MEAN, FN_COL_MEAN: begin
            fn_sum  = 1'b1;
            fn_mean = 1'b1;
         end
         default:                  fn_known = 1'b0;
      endcase
   end

   // Cell writes go straight into the store on the request beat.
   assign mem_wr.we   = req_fire && fn_known && fn_write && !idx_bad;
   assign mem_wr.addr = cell_addr(req_row, req_col);
   assign mem_wr.data = req_bus.operand_value;

   // Scan address: walk the columns of a row or the rows of a column.
   assign rd_addr = by_row_ff ? cell_addr(row_ff, COL_W'(cnt_ff))
                              : cell_addr(ROW_W'(cnt_ff), col_ff);

   mrcr_cell_mem u_cell_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared adder: acc + cell when summing, cell - acc when comparing.
   always_comb begin
      data_ext = ACC_W'(rd_data);
      op_a     = sum_mode_ff ? acc_ff : data_ext;
      op_b     = sum_mode_ff ? data_ext : ~acc_ff;
      alu_out  = op_a + op_b + ACC_W'(!sum_mode_ff);
      take     = max_mode_ff ? (!alu_out[ACC_W-1] && (alu_out != '0)) : alu_out[ACC_W-1];
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = signed'(acc_ff);
   assign div_req.divisor  = len_ff;

   mrcr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      by_row_in     = by_row_ff;
      sum_mode_in   = sum_mode_ff;
      max_mode_in   = max_mode_ff;
      mean_in       = mean_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      rd_vld_in     = 1'b0;
      rd_first_in   = 1'b0;
      res_in        = res_ff;
      sts_in        = sts_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;

      // The output register empties when its beat is taken.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Fold in the cell read in the previous cycle.
      if (rd_vld_ff) begin
         if (sum_mode_ff) begin
            acc_in = alu_out;
         end else if (rd_first_ff || take) begin
            acc_in = data_ext;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               by_row_in   = req_bus.func[0];
               sum_mode_in = fn_sum;
               max_mode_in = fn_max;
               mean_in     = fn_mean;
               row_in      = req_row;
               col_in      = req_col;
               len_in      = req_bus.func[0] ? eff_cols : eff_rows;
               cnt_in      = '0;
               acc_in      = ACC_W'(req_bus.operand_value);
               res_in      = '0;
               sts_in      = 1'b0;
               if (!fn_known) begin
                  state_in = ST_DONE;
               end else if (idx_bad) begin
                  sts_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (fn_write) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_vld_in   = 1'b1;
            rd_first_in = (cnt_ff == '0);
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == len_ff - 1'b1) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (mean_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               res_in   = sum_mode_ff ? sat_q32(acc_ff) : acc_ff[Q_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_in   = sat_q32(div_rsp.quotient);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = sts_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_count_ff <= COUNT_RST;
         col_count_ff <= COUNT_RST;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      by_row_ff     <= by_row_in;
      sum_mode_ff   <= sum_mode_in;
      max_mode_ff   <= max_mode_in;
      mean_ff       <= mean_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      rd_first_ff   <= rd_first_in;
      res_ff        <= res_in;
      sts_ff        <= sts_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = signed'(rsp_value_ff);
   assign rsp_bus.status       = rsp_status_ff;

   // A request beat always leaves the idle state on the next cycle.
   a_fire_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // The scan counter never runs past the row or column length.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff < len_ff))
      else $error("scan counter beyond length");

   // A divider answer only arrives while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // The cell store is written only on an accepted write request.
   a_write_on_fire: assert property (@(posedge clock) disable iff (reset)
      mem_wr.we |-> (req_fire && (req_bus.func == FN_WRITE)))
      else $error("cell store written without a write request");

endmodule

### src/mrcr_cell_mem.sv
module mrcr_cell_mem import mrcr_pkg::*; (
   input  logic                  clock,
   input  mem_wr_type            wr,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic signed [Q_W-1:0] rd_data
);

   logic [Q_W-1:0] cell_mem_ff [DEPTH];
   logic [Q_W-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         cell_mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= cell_mem_ff[rd_addr];
   end

   assign rd_data = signed'(rd_data_ff);

endmodule

### src/mrcr_div.sv
module mrcr_div import mrcr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]     dvd_ff, dvd_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     dsr_ff, dsr_in;
   logic [ACC_W-1:0]     quo_ff, quo_in;

   logic [LEN_W:0]       trial;
   logic [LEN_W:0]       diff;
   logic                 fits;
   logic [LEN_W-1:0]     rem_step;
   logic [ACC_W-1:0]     dvd_step;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial    = {rem_ff, dvd_ff[ACC_W-1]};
      diff     = trial - {1'b0, dsr_ff};
      fits     = trial >= {1'b0, dsr_ff};
      rem_step = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      dvd_step = {dvd_ff[ACC_W-2:0], fits};
   end

   // Sequencer: load magnitudes, run ACC_W steps, restore the sign.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(ACC_W);
         neg_in  = req.dividend[ACC_W-1];
         dvd_in  = req.dividend[ACC_W-1] ? -req.dividend : req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         dvd_in = dvd_step;
         rem_in = rem_step;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? -dvd_step : dvd_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = signed'(quo_ff);

endmodule
